// File: sv/slm_pkg.sv
// ============================================================================
// slm_pkg - shared types and constants for the subsampled luma MSE block
// Field widths, register indexes, state encodings and the divider status.
// ============================================================================
package slm_pkg;

  localparam int unsigned LumaW      = 8;
  localparam int unsigned RegW       = 13;
  localparam int unsigned SumW       = 38;
  localparam int unsigned MeanW      = 24;
  localparam int unsigned CntOutW    = 23;
  localparam int unsigned FracW      = 8;
  localparam int unsigned SqW        = 2 * LumaW;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned DefMaxWidth  = 4096;
  localparam int unsigned DefMaxHeight = 4096;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIVIDE,
    ST_EMIT
  } top_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_RUN,
    DV_DONE
  } div_state_e;

  // position flags of the pixel at the counters
  typedef struct packed {
    logic sample;
    logic frame_end;
  } pos_info_t;

  // divider handshake toward the sequencer
  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// File: sv/subsampled_luma_mse_top.sv
// ============================================================================
// subsampled_luma_mse_top - subsampled luma mean squared error
// Accumulates squared luma differences over even rows and columns and emits
// the frame sum, sample count and 8-fraction-bit mean on the last pixel.
// ============================================================================
// Flow: an ordinary pixel item occupies the block through the accept state
//   and then the square and accumulate state. The last pixel of a frame
//   also goes through one overflow check, 24 divider steps, a done state and
//   the result load, which waits while the result slot is full. No new item
//   is taken until the block is back in its idle state.
// Reset: rst_ni is asynchronous, active low; it clears the position counters,
//   the accumulator and the sequencer, and sets both size registers to 1.
module subsampled_luma_mse_top #(
  parameter int unsigned MAX_WIDTH  = slm_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = slm_pkg::DefMaxHeight
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pixel pair channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [slm_pkg::LumaW-1:0]      prev_luma_i,
  input  logic [slm_pkg::LumaW-1:0]      curr_luma_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [slm_pkg::MeanW-1:0]      mean_sq_q8_o,
  output logic [slm_pkg::SumW-1:0]       sum_squares_o,
  output logic [slm_pkg::CntOutW-1:0]    sample_count_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [slm_pkg::ApbAddrW-1:0]   paddr,
  input  logic [slm_pkg::ApbDataW-1:0]   pwdata,
  output logic [slm_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);
  import slm_pkg::*;

  localparam int unsigned HWW   = $clog2((MAX_WIDTH + 1) / 2 + 1);
  localparam int unsigned HWH   = $clog2((MAX_HEIGHT + 1) / 2 + 1);
  localparam int unsigned CNT_W = HWW + HWH;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RegW-1:0] width_q, height_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RegW'(1);
      height_q <= RegW'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FRAME_WIDTH) begin
        width_q <= pwdata[RegW-1:0];
      end else begin
        height_q <= pwdata[RegW-1:0];
      end
    end
  end

  // read back the addressed size register
  always_comb begin
    if (paddr[2] == REG_FRAME_WIDTH) begin
      prdata = ApbDataW'(width_q);
    end else begin
      prdata = ApbDataW'(height_q);
    end
  end

  // --------------------------------------------------------------------------
  // Position counters
  // --------------------------------------------------------------------------
  pos_info_t        pos_info;
  logic [CNT_W-1:0] count;
  logic             in_acc;

  assign in_acc = in_valid_i & in_ready_o;

  slm_frame_ctr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CNT_W      (CNT_W)
  ) u_ctr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .width_reg_i  (width_q),
    .height_reg_i (height_q),
    .advance_i    (in_acc),
    .info_o       (pos_info),
    .count_o      (count)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  top_state_e state_q, state_d;
  div_ctl_t   div_ctl;
  logic       emit_go;
  logic       out_valid_q, out_valid_d;
  logic       samp_q;
  logic       fend_q;

  // the result slot frees when empty or when its item is being taken
  assign emit_go = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_ACCUM;
      ST_ACCUM:  state_d = fend_q ? ST_DIVIDE : ST_IDLE;
      ST_DIVIDE: if (div_ctl.done) state_d = ST_EMIT;
      ST_EMIT:   if (emit_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
  end

  assign div_ctl.start = (state_q == ST_ACCUM) && fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Square and accumulate
  // --------------------------------------------------------------------------
  logic [LumaW-1:0] diff_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SqW-1:0]   square;
  logic [SumW:0]    sum_wide;
  logic [SumW-1:0]  sum_q, sum_d;

  // latch the pixel's difference and position flags on accept
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      diff_q <= (prev_luma_i > curr_luma_i) ? (prev_luma_i - curr_luma_i)
                                            : (curr_luma_i - prev_luma_i);
      cnt_q  <= count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_q <= 1'b0;
      fend_q <= 1'b0;
    end else if (in_acc) begin
      samp_q <= pos_info.sample;
      fend_q <= pos_info.frame_end;
    end
  end

  assign square   = samp_q ? (SqW'(diff_q) * SqW'(diff_q)) : '0;
  assign sum_wide = {1'b0, sum_q} + (SumW+1)'(square);

  // saturate on carry out; drop the sum once the result is loaded
  always_comb begin
    sum_d = sum_q;
    if (state_q == ST_ACCUM) begin
      sum_d = sum_wide[SumW] ? '1 : sum_wide[SumW-1:0];
    end else if ((state_q == ST_EMIT) && emit_go) begin
      sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // --------------------------------------------------------------------------
  // Mean divider
  // --------------------------------------------------------------------------
  logic [MeanW-1:0] quot;

  slm_divider #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_ctl.start),
    .sum_i     (sum_d),
    .divisor_i (cnt_q),
    .done_o    (div_ctl.done),
    .quot_o    (quot)
  );

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [MeanW-1:0]   mean_q;
  logic [SumW-1:0]    sum_out_q;
  logic [CntOutW-1:0] cnt_out_q;
  logic               load_out;

  assign load_out = (state_q == ST_EMIT) && emit_go;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      mean_q    <= quot;
      sum_out_q <= sum_q;
      cnt_out_q <= CntOutW'(cnt_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mean_sq_q8_o   = mean_q;
  assign sum_squares_o  = sum_out_q;
  assign sample_count_o = cnt_out_q;

endmodule

// File: sv/slm_frame_ctr.sv
// ============================================================================
// slm_frame_ctr - raster position counters
// Clamps the size registers, tracks column and row, flags sampled pixels and
// the frame end, and forms the sample count ceil(h/2)*ceil(w/2).
// ============================================================================
module slm_frame_ctr #(
  parameter int unsigned MAX_WIDTH  = slm_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = slm_pkg::DefMaxHeight,
  parameter int unsigned CNT_W      = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [slm_pkg::RegW-1:0]   width_reg_i,
  input  logic [slm_pkg::RegW-1:0]   height_reg_i,
  input  logic                       advance_i,
  output slm_pkg::pos_info_t         info_o,
  output logic [CNT_W-1:0]           count_o
);
  import slm_pkg::*;

  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned HWW  = $clog2((MAX_WIDTH + 1) / 2 + 1);
  localparam int unsigned HWH  = $clog2((MAX_HEIGHT + 1) / 2 + 1);

  logic [WW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [WW:0]   w_plus;
  logic [HW:0]   h_plus;
  logic [HWW-1:0] w_half;
  logic [HWH-1:0] h_half;
  logic          row_end;

  // zero acts as one, oversize saturates to the maximum
  always_comb begin
    if (width_reg_i == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_reg_i) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_reg_i);
    end
    if (height_reg_i == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_reg_i) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_reg_i);
    end
  end

  assign row_end          = ({1'b0, col_q} + (WW+1)'(1)) >= {1'b0, w_eff};
  assign info_o.frame_end = row_end && (({1'b0, row_q} + (HW+1)'(1)) >= {1'b0, h_eff});
  assign info_o.sample    = ~col_q[0] & ~row_q[0];

  assign w_plus  = {1'b0, w_eff} + (WW+1)'(1);
  assign h_plus  = {1'b0, h_eff} + (HW+1)'(1);
  assign w_half  = HWW'(w_plus >> 1);
  assign h_half  = HWH'(h_plus >> 1);
  assign count_o = CNT_W'(h_half) * CNT_W'(w_half);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (info_o.frame_end) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + HW'(1);
      end else begin
        col_d = col_q + WW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// File: sv/slm_divider.sv
// ============================================================================
// slm_divider - iterative restoring divider for the frame mean
// Computes floor(sum * 256 / count), one quotient bit per cycle, saturating
// at the 24-bit maximum.
// ============================================================================
module slm_divider #(
  parameter int unsigned CNT_W = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [slm_pkg::SumW-1:0]   sum_i,
  input  logic [CNT_W-1:0]           divisor_i,
  output logic                       done_o,
  output logic [slm_pkg::MeanW-1:0]  quot_o
);
  import slm_pkg::*;

  // high part of the dividend that lies above the quotient bits
  localparam int unsigned HiW   = SumW + FracW - MeanW;
  localparam int unsigned LoW   = SumW - HiW;
  localparam int unsigned RemW  = ((CNT_W > HiW) ? CNT_W : HiW) + 1;
  localparam int unsigned StepW = $clog2(MeanW);

  div_state_e state_q, state_d;
  logic [RemW-1:0]  rem_q;
  logic [MeanW-1:0] low_q;
  logic [CNT_W-1:0] div_q;
  logic [StepW-1:0] step_q;
  logic [RemW-1:0]  div_ext;
  logic [RemW-1:0]  trial;
  logic             fits;
  logic             last_step;

  assign div_ext   = RemW'(div_q);
  assign trial     = {rem_q[RemW-2:0], low_q[MeanW-1]};
  assign fits      = trial >= div_ext;
  assign last_step = step_q == StepW'(MeanW - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      DV_IDLE:  if (start_i) state_d = DV_CHECK;
      DV_CHECK: state_d = (rem_q >= div_ext) ? DV_DONE : DV_RUN;
      DV_RUN:   if (last_step) state_d = DV_DONE;
      DV_DONE:  state_d = DV_IDLE;
      default:  state_d = DV_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == DV_DONE);
  end

  assign quot_o = low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath: low_q shifts dividend bits out and quotient bits in
  always_ff @(posedge clk_i) begin
    case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          rem_q  <= RemW'(sum_i[SumW-1:LoW]);
          low_q  <= {sum_i[LoW-1:0], FracW'(0)};
          div_q  <= divisor_i;
          step_q <= '0;
        end
      end
      DV_CHECK: begin
        if (rem_q >= div_ext) begin
          low_q <= '1;
        end
      end
      DV_RUN: begin
        rem_q  <= fits ? (trial - div_ext) : trial;
        low_q  <= {low_q[MeanW-2:0], fits};
        step_q <= step_q + StepW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/slm_checker.sv
// ============================================================================
// slm_checker - port-level checks for the subsampled luma MSE block
// Watches the item channels of the top level and is bound to it below.
// ============================================================================
module slm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [slm_pkg::MeanW-1:0]    mean_sq_q8_o,
  input logic [slm_pkg::SumW-1:0]     sum_squares_o,
  input logic [slm_pkg::CntOutW-1:0]  sample_count_o
);
  import slm_pkg::*;

  // a result item holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sum_squares_o)
      && $stable(mean_sq_q8_o) && $stable(sample_count_o))
    else $error("result item changed while stalled");

  // one item at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted in back-to-back cycles");

  // a frame always has at least one sampled pixel
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_count_o != '0)
    else $error("zero sample count in result");

  // no error energy means a zero mean
  a_zero_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sum_squares_o == '0) |-> mean_sq_q8_o == '0)
    else $error("nonzero mean with zero sum");

endmodule

bind subsampled_luma_mse_top slm_checker u_slm_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench - self-checking bench for subsampled_luma_mse_top
// Streams luma pixel pairs into the block and predicts every per-frame result
// with its own accumulator model. Each result is compared field by field.
// The run covers directed corner frames, one long row, a long output
// hold-off and randomly sized frames under several idling patterns.
// ============================================================================
module testbench;
  import slm_pkg::*;

  localparam int unsigned MaxW         = DefMaxWidth;
  localparam int unsigned MaxH         = DefMaxHeight;
  localparam int          RandomItems  = 1010;
  localparam int          RowPixels    = 256;
  // lets a pixel still inside the block settle; leave margin before a write
  localparam int          DrainCycles  = 40;
  localparam int          LongHold     = 400;
  localparam longint unsigned SumLimit  = (64'd1 << SumW) - 1;
  localparam longint unsigned MeanLimit = (64'd1 << MeanW) - 1;

  typedef struct packed {
    logic [LumaW-1:0] prev;
    logic [LumaW-1:0] curr;
  } luma_pair_t;

  typedef struct packed {
    logic [MeanW-1:0]   mean_sq_q8;
    logic [SumW-1:0]    sum_squares;
    logic [CntOutW-1:0] sample_count;
  } frame_mse_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // --------------------------------------------------------------------------
  // DUT signals; the driven ones are known from time zero
  // --------------------------------------------------------------------------
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [LumaW-1:0]    prev_luma_i    = '0;
  logic [LumaW-1:0]    curr_luma_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [MeanW-1:0]    mean_sq_q8_o;
  logic [SumW-1:0]     sum_squares_o;
  logic [CntOutW-1:0]  sample_count_o;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [ApbAddrW-1:0] paddr          = '0;
  logic [ApbDataW-1:0] pwdata         = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  subsampled_luma_mse_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .prev_luma_i    (prev_luma_i),
    .curr_luma_i    (curr_luma_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mean_sq_q8_o   (mean_sq_q8_o),
    .sum_squares_o  (sum_squares_o),
    .sample_count_o (sample_count_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  luma_pair_t  pixel_queue[$];   // pixel pairs waiting for the driver
  frame_mse_t  mse_expected[$];  // predicted frame results, oldest first
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic        pair_taken     = 1'b0;
  logic        hold_req       = 1'b0;
  logic        hold_ack       = 1'b0;
  int          hold_left      = 0;
  int          err_cnt        = 0;
  int          frames_checked = 0;
  int          pixels_sent    = 0;

  // accumulator model: size registers, raster position and running sum
  logic [RegW-1:0]  width_reg  = 13'd1;
  logic [RegW-1:0]  height_reg = 13'd1;
  int unsigned      col_at     = 0;
  int unsigned      row_at     = 0;
  longint unsigned  sq_sum     = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Pixel driver: advance to the next item only once the current one is taken
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : pixel_driver
    luma_pair_t pair;
    if (rst_ni && (!in_valid_i || pair_taken)) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        pair = pixel_queue.pop_front();
        in_valid_i  <= 1'b1;
        prev_luma_i <= pair.prev;
        curr_luma_i <= pair.curr;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : result_receiver
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= LongHold;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted pixel, check every accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : frame_monitor
    int unsigned     w_eff, h_eff, diff;
    longint unsigned cnt, mean;
    logic            row_end;
    frame_mse_t      want, got;

    pair_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pixels_sent++;
        // zero acts as one, anything past the maximum clamps to it
        w_eff = (width_reg == 0) ? 1 : ((width_reg > MaxW) ? MaxW : width_reg);
        h_eff = (height_reg == 0) ? 1 : ((height_reg > MaxH) ? MaxH : height_reg);
        // only even rows and even columns contribute
        if (!col_at[0] && !row_at[0]) begin
          diff = (prev_luma_i > curr_luma_i) ? prev_luma_i - curr_luma_i
                                             : curr_luma_i - prev_luma_i;
          if (sq_sum > SumLimit - diff * diff) sq_sum = SumLimit;
          else sq_sum = sq_sum + diff * diff;
        end
        // bounds compare with >= so a counter past a shrunken size ends at once
        row_end = (col_at + 1 >= w_eff);
        if (row_end && (row_at + 1 >= h_eff)) begin
          cnt  = longint'((h_eff + 1) / 2) * longint'((w_eff + 1) / 2);
          mean = (sq_sum << FracW) / cnt;
          if (mean > MeanLimit) mean = MeanLimit;
          want.mean_sq_q8   = mean[MeanW-1:0];
          want.sum_squares  = sq_sum[SumW-1:0];
          want.sample_count = cnt[CntOutW-1:0];
          mse_expected.push_back(want);
          col_at = 0;
          row_at = 0;
          sq_sum = 0;
        end else if (row_end) begin
          col_at = 0;
          row_at = row_at + 1;
        end else begin
          col_at = col_at + 1;
        end
      end

      if (out_valid_o && out_ready_i) begin
        got.mean_sq_q8   = mean_sq_q8_o;
        got.sum_squares  = sum_squares_o;
        got.sample_count = sample_count_o;
        if (mse_expected.size() == 0) begin
          $error("unexpected result: mean_sq_q8 %0d sum_squares %0d sample_count %0d",
                 got.mean_sq_q8, got.sum_squares, got.sample_count);
          err_cnt++;
        end else begin
          want = mse_expected.pop_front();
          frames_checked++;
          if (got.mean_sq_q8 !== want.mean_sq_q8) begin
            $error("mean_sq_q8: expected %0d, actual %0d", want.mean_sq_q8, got.mean_sq_q8);
            err_cnt++;
          end
          if (got.sum_squares !== want.sum_squares) begin
            $error("sum_squares: expected %0d, actual %0d",
                   want.sum_squares, got.sum_squares);
            err_cnt++;
          end
          if (got.sample_count !== want.sample_count) begin
            $error("sample_count: expected %0d, actual %0d",
                   want.sample_count, got.sample_count);
            err_cnt++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_pixel(logic [LumaW-1:0] prev, logic [LumaW-1:0] curr);
    luma_pair_t pair;
    pair.prev = prev;
    pair.curr = curr;
    pixel_queue.push_back(pair);
  endfunction

  // bias toward the byte extremes so large differences show up often
  function automatic logic [LumaW-1:0] rand_luma();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return LumaW'($urandom_range(255));
  endfunction

  function automatic logic [RegW-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 80) return RegW'($urandom_range(1, 8));
    return RegW'($urandom_range(9, 40));
  endfunction

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 87; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 87; end
      IDLE_BOTH: begin send_idle_pct = 20; recv_stall_pct = 20; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // Hold until the pixel stream is drained and all frames are out, then let
  // any pixel still inside the block settle.
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || in_valid_i || mse_expected.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_size(reg_idx_e idx, logic [ApbDataW-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata !== ApbDataW'(data[RegW-1:0])) begin
      $error("prdata: expected %0d, actual %0d", data[RegW-1:0], prdata);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = data[RegW-1:0];
    else height_reg = data[RegW-1:0];
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    int          random_items;
    int          phase_no;
    int unsigned area, n_pix;
    logic [RegW-1:0] w_sz, h_sz;

    random_items = 0;
    phase_no     = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset sizes are 1x1: every pixel is a frame, extremes of the mean.
    set_idling(IDLE_NONE);
    queue_pixel(8'd0, 8'd255);
    queue_pixel(8'd255, 8'd0);
    queue_pixel(8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255);
    wait_idle();

    // Odd 3x3 frame: count rounds up to 2x2 samples.
    write_size(REG_FRAME_WIDTH, 32'd3);
    write_size(REG_FRAME_HEIGHT, 32'd3);
    queue_pixel(8'd255, 8'd0);
    queue_pixel(8'd0, 8'd0);
    queue_pixel(8'd0, 8'd255);
    queue_pixel(8'd12, 8'd200);
    queue_pixel(8'd255, 8'd255);
    queue_pixel(8'd1, 8'd0);
    queue_pixel(8'd7, 8'd250);
    queue_pixel(8'd0, 8'd128);
    queue_pixel(8'd200, 8'd3);
    wait_idle();

    // Width zero acts as one; junk above the 13 register bits is dropped.
    write_size(REG_FRAME_WIDTH, 32'hFFFF_E000);
    write_size(REG_FRAME_HEIGHT, 32'd2);
    queue_pixel(8'd100, 8'd37);
    queue_pixel(8'd255, 8'd0);
    wait_idle();

    // Clamped height, then shrink mid-frame: the row counter is past the new
    // bound, the frame closes on the next pixel and the mean saturates.
    write_size(REG_FRAME_WIDTH, 32'd1);
    write_size(REG_FRAME_HEIGHT, 32'hFFFF_FFFF);
    repeat (3) begin
      queue_pixel(8'd0, 8'd255);
      queue_pixel(8'd255, 8'd0);
    end
    wait_idle();
    write_size(REG_FRAME_HEIGHT, 32'd1);
    queue_pixel(8'd255, 8'd0);
    wait_idle();

    // One long row; height has bit 13 only, so it reads as zero.
    write_size(REG_FRAME_WIDTH, 32'(RowPixels));
    write_size(REG_FRAME_HEIGHT, 32'h0000_2000);
    repeat (RowPixels) queue_pixel(rand_luma(), rand_luma());
    wait_idle();

    // Long output hold-off with a busy sender: let the block fill and stall.
    write_size(REG_FRAME_WIDTH, 32'd1);
    write_size(REG_FRAME_HEIGHT, 32'd1);
    hold_req = ~hold_req;
    repeat (60) queue_pixel(rand_luma(), rand_luma());
    wait_idle();

    // Random phases: whole frames of random size, sometimes a trailing partial
    // frame so the next size change lands mid-frame.
    while (random_items < RandomItems) begin
      set_idling(idle_mode_e'(phase_no % 4));
      w_sz = pick_size();
      h_sz = pick_size();
      write_size(REG_FRAME_WIDTH, ($urandom() & 32'hFFFF_E000) | w_sz);
      write_size(REG_FRAME_HEIGHT, ($urandom() & 32'hFFFF_E000) | h_sz);
      area  = ((w_sz == 0) ? 1 : w_sz) * ((h_sz == 0) ? 1 : h_sz);
      n_pix = area * ((area > 200) ? 1 : $urandom_range(1, 4));
      if ($urandom_range(3) == 0) n_pix += $urandom_range(1, area);
      // keep the item total near the planned count
      if (n_pix > unsigned'(RandomItems - random_items))
        n_pix = unsigned'(RandomItems - random_items);
      repeat (n_pix) queue_pixel(rand_luma(), rand_luma());
      random_items += n_pix;
      phase_no++;
      wait_idle();
    end

    $display("Checked %0d frame results from %0d pixel items over %0d random phases,",
             frames_checked, pixels_sent, phase_no);
    $display("including zero, clamped and mid-frame size changes and a saturated mean.");
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: subsampled_luma_mse_top.f
sv/slm_pkg.sv
sv/slm_frame_ctr.sv
sv/slm_divider.sv
sv/subsampled_luma_mse_top.sv
sv/slm_checker.sv
test/testbench.sv
